[rtl/lpht_pkg.sv]
`timescale 1ns / 1ps

package lpht_pkg;

    // Two-bit code carried by kind, slot state and result status.
    typedef logic [1:0] code_t;

    // Operation kinds on the input tuser.
    localparam code_t KIND_INSERT = 2'd0;
    localparam code_t KIND_DELETE = 2'd1;
    localparam code_t KIND_SEARCH = 2'd2;

    // Per-slot state kept next to each stored key.
    localparam code_t SLOT_EMPTY = 2'd0;
    localparam code_t SLOT_USED  = 2'd1;
    localparam code_t SLOT_GONE  = 2'd2;

    // Result status on the output tuser.
    localparam code_t STAT_OK   = 2'd0;
    localparam code_t STAT_MISS = 2'd1;
    localparam code_t STAT_FULL = 2'd2;

    // One result beat, before packing onto the output bus.
    typedef struct packed {
        code_t      status;
        logic [3:0] slot;
        logic [4:0] occupancy;
    } result_t;

endpackage

[rtl/linear_probe_hash_table.sv]
`timescale 1ns / 1ps

// Open-addressing hash table with linear probing and tombstones.
// Input beat: s_tuser carries the operation (insert, delete, search) and
// s_tdata the key. Each accepted beat produces exactly one result beat:
// m_tuser carries the status (done or found, not found, table full) and
// m_tdata the slot and the number of live keys after the operation.
// One operation is in flight at a time; s_tready is low while it runs.
// After the beat is accepted the home slot is hashed, then 1 to TABLE_SIZE
// slots are probed, one slot per cycle through the single read port of the
// slot memory, and the result is loaded into the output register once it is
// free. s_tready comes back together with m_tvalid, so a new beat is taken
// only once the last one has its result. When TABLE_SIZE is not a power of
// two the home slot is folded one hash byte per cycle and then reduced by a
// reciprocal multiply.
// After reset the block sweeps the slot memory to empty, one slot a cycle,
// before s_tready rises. A finished result waits in the output register
// while m_tready is low; the next beat is accepted meanwhile, but its result
// is held back until the register frees up.
module linear_probe_hash_table_top #(
    parameter int TABLE_SIZE = 16,
    parameter int KEY_WIDTH  = 32
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // [31:0] key
    input  logic [1:0]  s_tuser,   // [1:0] kind
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // [3:0] slot, [8:4] occupancy, [15:9] zero
    output logic [1:0]  m_tuser    // [1:0] status
);

    localparam int KW = (KEY_WIDTH < 32) ? KEY_WIDTH : 32;
    localparam int IW = $clog2(TABLE_SIZE);

    logic              hash_start;
    logic [KW-1:0]     hash_key;
    logic              hash_done;
    logic [IW-1:0]     hash_home;
    logic              mem_we;
    logic [IW-1:0]     mem_waddr;
    logic [KW+1:0]     mem_wdata;
    logic [IW-1:0]     mem_raddr;
    logic [KW+1:0]     mem_rdata;
    lpht_pkg::result_t result;

    lpht_hash #(
        .TABLE_SIZE (TABLE_SIZE),
        .KEY_WIDTH  (KEY_WIDTH)
    ) u_hash (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (hash_start),
        .key     (hash_key),
        .done    (hash_done),
        .home    (hash_home)
    );

    lpht_mem #(
        .DEPTH (TABLE_SIZE),
        .WIDTH (KW + 2)
    ) u_mem (
        .aclk  (aclk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    lpht_ctrl #(
        .TABLE_SIZE (TABLE_SIZE),
        .KEY_WIDTH  (KEY_WIDTH)
    ) u_ctrl (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_kind     (s_tuser),
        .s_key      (s_tdata),
        .hash_start (hash_start),
        .hash_key   (hash_key),
        .hash_done  (hash_done),
        .hash_home  (hash_home),
        .mem_we     (mem_we),
        .mem_waddr  (mem_waddr),
        .mem_wdata  (mem_wdata),
        .mem_raddr  (mem_raddr),
        .mem_rdata  (mem_rdata),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_result   (result)
    );

    // Pack the result beat onto the output bus.
    assign m_tuser = result.status;
    assign m_tdata = {7'd0, result.occupancy, result.slot};

    // Only one operation runs at a time.
    a_one_in_flight: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input accepted while an operation was running");

    // A failed operation never reports a slot.
    a_slot_zero_on_fail: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser != lpht_pkg::STAT_OK |-> m_tdata[3:0] == 4'd0)
        else $error("nonzero slot on a failed operation");

    // A full report only comes with every slot live.
    a_full_means_all_live: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser == lpht_pkg::STAT_FULL |-> m_tdata[8:4] == 5'(TABLE_SIZE))
        else $error("table full reported with free slots");

    // Live count never exceeds the table size.
    a_occupancy_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (TABLE_SIZE > 31) || (32'(m_tdata[8:4]) <= 32'(TABLE_SIZE)))
        else $error("occupancy above table size");

endmodule

[rtl/lpht_hash.sv]
`timescale 1ns / 1ps

module lpht_hash #(
    parameter int TABLE_SIZE = 16,
    parameter int KEY_WIDTH  = 32
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          start,
    input  logic [((KEY_WIDTH < 32) ? KEY_WIDTH : 32)-1:0] key,
    output logic                          done,
    output logic [$clog2(TABLE_SIZE)-1:0] home
);

    localparam int HW = (KEY_WIDTH < 35) ? KEY_WIDTH : 35;
    localparam int IW = $clog2(TABLE_SIZE);
    localparam bit IS_POW2 = ((1 << IW) == TABLE_SIZE);

    logic [34:0]   key_wide;
    logic [34:0]   sum_wide;
    logic [HW-1:0] hash_val;

    // Weight of byte j of the hash, taken modulo the table size.
    function automatic int pow256_mod(int j);
        int v;
        v = 1 % TABLE_SIZE;
        for (int i = 0; i < j; i++) begin
            v = (v * 256) % TABLE_SIZE;
        end
        return v;
    endfunction

    // Multiply by five as shift plus add, add three, then wrap to KEY_WIDTH bits, at most 35.
    assign key_wide = 35'(key);
    assign sum_wide = (key_wide << 2) + key_wide + 35'd3;
    assign hash_val = sum_wide[HW-1:0];

    if (IS_POW2) begin : g_pow2
        logic          done_reg;
        logic [IW-1:0] home_reg;

        // A power-of-two table size keeps the low bits of the hash.
        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                done_reg <= 1'b0;
            end else begin
                done_reg <= start;
            end
            if (start) begin
                home_reg <= IW'(hash_val);
            end
        end

        assign done = done_reg;
        assign home = home_reg;
    end else begin : g_fold
        localparam int NB = (HW + 7) / 8;
        localparam int SW = NB * 8;
        localparam int AW = 23;
        localparam int PW = 2 * AW;
        localparam int RW = IW + 1;
        localparam int W0 = pow256_mod(0);
        localparam int W1 = pow256_mod(1);
        localparam int W2 = pow256_mod(2);
        localparam int W3 = pow256_mod(3);
        localparam int W4 = pow256_mod(4);
        localparam logic [AW-1:0] RECIP = AW'((1 << AW) / TABLE_SIZE);
        localparam logic [AW-1:0] MODV  = AW'(TABLE_SIZE);

        logic          busy_reg;
        logic          done_reg;
        logic [2:0]    step_reg;
        logic [SW-1:0] shift_reg;
        logic [AW-1:0] acc_reg;
        logic [AW-1:0] q_reg;
        logic [RW-1:0] rem_reg;
        logic [IW-1:0] home_reg;
        logic [11:0]   weight;
        logic [19:0]   term;
        logic [PW-1:0] q_prod;
        logic [AW-1:0] qm_prod;

        // Each hash byte is weighted by its power of 256 modulo the table size.
        always_comb begin
            case (step_reg)
                3'd0:    weight = 12'(W0);
                3'd1:    weight = 12'(W1);
                3'd2:    weight = 12'(W2);
                3'd3:    weight = 12'(W3);
                3'd4:    weight = 12'(W4);
                default: weight = 12'd0;
            endcase
        end

        // The folded sum stays below 2^23, so a 23-bit reciprocal gives a
        // quotient that is at most one short; one compare and subtract fixes it.
        assign term    = {12'd0, shift_reg[7:0]} * {8'd0, weight};
        assign q_prod  = PW'(acc_reg) * PW'(RECIP);
        assign qm_prod = q_reg * MODV;

        // Fold one byte per cycle, then quotient, remainder and final correction.
        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                busy_reg <= 1'b0;
                done_reg <= 1'b0;
                step_reg <= '0;
            end else begin
                done_reg <= 1'b0;
                if (start) begin
                    busy_reg <= 1'b1;
                    step_reg <= '0;
                end else if (busy_reg) begin
                    if (step_reg == 3'(NB + 2)) begin
                        busy_reg <= 1'b0;
                        done_reg <= 1'b1;
                    end
                    step_reg <= step_reg + 3'd1;
                end
            end
            if (start) begin
                shift_reg <= SW'(hash_val);
                acc_reg   <= '0;
            end else if (busy_reg) begin
                if (step_reg < 3'(NB)) begin
                    acc_reg   <= acc_reg + AW'(term);
                    shift_reg <= shift_reg >> 8;
                end
                if (step_reg == 3'(NB)) begin
                    q_reg <= q_prod[PW-1:AW];
                end
                if (step_reg == 3'(NB + 1)) begin
                    rem_reg <= RW'(acc_reg - qm_prod);
                end
                if (step_reg == 3'(NB + 2)) begin
                    home_reg <= (rem_reg >= RW'(TABLE_SIZE))
                                ? IW'(rem_reg - RW'(TABLE_SIZE)) : IW'(rem_reg);
                end
            end
        end

        assign done = done_reg;
        assign home = home_reg;
    end

endmodule

[rtl/lpht_mem.sv]
`timescale 1ns / 1ps

module lpht_mem #(
    parameter int DEPTH = 16,
    parameter int WIDTH = 34
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // One write port and one read port with registered read data.
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

[rtl/lpht_ctrl.sv]
`timescale 1ns / 1ps

module lpht_ctrl #(
    parameter int TABLE_SIZE = 16,
    parameter int KEY_WIDTH  = 32
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    // Input beat
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  lpht_pkg::code_t               s_kind,
    input  logic [31:0]                   s_key,
    // Home slot unit
    output logic                          hash_start,
    output logic [((KEY_WIDTH < 32) ? KEY_WIDTH : 32)-1:0] hash_key,
    input  logic                          hash_done,
    input  logic [$clog2(TABLE_SIZE)-1:0] hash_home,
    // Slot memory
    output logic                          mem_we,
    output logic [$clog2(TABLE_SIZE)-1:0] mem_waddr,
    output logic [((KEY_WIDTH < 32) ? KEY_WIDTH : 32)+1:0] mem_wdata,
    output logic [$clog2(TABLE_SIZE)-1:0] mem_raddr,
    input  logic [((KEY_WIDTH < 32) ? KEY_WIDTH : 32)+1:0] mem_rdata,
    // Result beat
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output lpht_pkg::result_t             m_result
);

    localparam int KW = (KEY_WIDTH < 32) ? KEY_WIDTH : 32;
    localparam int IW = $clog2(TABLE_SIZE);
    localparam int CW = $clog2(TABLE_SIZE + 1);
    localparam logic [IW-1:0] LAST_IDX = IW'(TABLE_SIZE - 1);

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_HASH,
        S_PROBE,
        S_RESULT
    } ctrl_state_t;

    ctrl_state_t       state_reg, state_next;
    logic [IW-1:0]     idx_reg, idx_next;
    logic [IW-1:0]     cnt_reg, cnt_next;
    logic [CW-1:0]     live_reg, live_next;
    logic              m_tvalid_reg, m_tvalid_next;
    lpht_pkg::result_t m_result_reg, m_result_next;
    lpht_pkg::code_t   kind_reg, kind_next;
    logic [KW-1:0]     key_reg, key_next;
    lpht_pkg::code_t   res_status_reg, res_status_next;
    logic [IW-1:0]     res_slot_reg, res_slot_next;

    lpht_pkg::code_t   q_state;
    logic [KW-1:0]     q_key;
    logic [IW-1:0]     idx_wrap;
    logic              accept;

    assign q_state  = mem_rdata[KW+1:KW];
    assign q_key    = mem_rdata[KW-1:0];
    assign idx_wrap = (idx_reg == LAST_IDX) ? '0 : idx_reg + IW'(1);
    assign accept   = s_tvalid && s_tready;

    assign s_tready   = (state_reg == S_IDLE);
    assign hash_start = accept;
    assign hash_key   = s_key[KW-1:0];
    assign mem_raddr  = idx_next;
    assign mem_waddr  = idx_reg;
    assign m_tvalid   = m_tvalid_reg;
    assign m_result   = m_result_reg;

    // Sequencer: clear pass, hash wait, one slot probed per cycle, result hand-off.
    always_comb begin
        state_next      = state_reg;
        idx_next        = idx_reg;
        cnt_next        = cnt_reg;
        live_next       = live_reg;
        m_tvalid_next   = m_tvalid_reg && !m_tready;
        m_result_next   = m_result_reg;
        kind_next       = kind_reg;
        key_next        = key_reg;
        res_status_next = res_status_reg;
        res_slot_next   = res_slot_reg;
        mem_we          = 1'b0;
        mem_wdata       = {lpht_pkg::SLOT_EMPTY, KW'(0)};

        unique case (state_reg)
            S_CLEAR: begin
                mem_we    = 1'b1;
                mem_wdata = {lpht_pkg::SLOT_EMPTY, KW'(0)};
                idx_next  = idx_wrap;
                if (idx_reg == LAST_IDX) begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE: begin
                if (accept) begin
                    kind_next  = s_kind;
                    key_next   = s_key[KW-1:0];
                    state_next = S_HASH;
                end
            end
            S_HASH: begin
                if (hash_done) begin
                    idx_next   = hash_home;
                    cnt_next   = '0;
                    state_next = S_PROBE;
                end
            end
            S_PROBE: begin
                res_slot_next = idx_reg;
                if (kind_reg == lpht_pkg::KIND_INSERT) begin
                    if (q_state != lpht_pkg::SLOT_USED) begin
                        // First free or tombstoned slot takes the key.
                        mem_we          = 1'b1;
                        mem_wdata       = {lpht_pkg::SLOT_USED, key_reg};
                        live_next       = live_reg + CW'(1);
                        res_status_next = lpht_pkg::STAT_OK;
                        state_next      = S_RESULT;
                    end else if (cnt_reg == LAST_IDX) begin
                        res_status_next = lpht_pkg::STAT_FULL;
                        state_next      = S_RESULT;
                    end else begin
                        idx_next = idx_wrap;
                        cnt_next = cnt_reg + IW'(1);
                    end
                end else if (kind_reg == lpht_pkg::KIND_DELETE ||
                             kind_reg == lpht_pkg::KIND_SEARCH) begin
                    if (q_state == lpht_pkg::SLOT_EMPTY) begin
                        res_status_next = lpht_pkg::STAT_MISS;
                        state_next      = S_RESULT;
                    end else if (q_state == lpht_pkg::SLOT_USED && q_key == key_reg) begin
                        res_status_next = lpht_pkg::STAT_OK;
                        state_next      = S_RESULT;
                        if (kind_reg == lpht_pkg::KIND_DELETE) begin
                            // Tombstone keeps the stored key bits as they are.
                            mem_we    = 1'b1;
                            mem_wdata = {lpht_pkg::SLOT_GONE, q_key};
                            if (live_reg != '0) begin
                                live_next = live_reg - CW'(1);
                            end
                        end
                    end else if (cnt_reg == LAST_IDX) begin
                        res_status_next = lpht_pkg::STAT_MISS;
                        state_next      = S_RESULT;
                    end else begin
                        idx_next = idx_wrap;
                        cnt_next = cnt_reg + IW'(1);
                    end
                end else begin
                    // Unused kind changes nothing and reports a miss.
                    res_status_next = lpht_pkg::STAT_MISS;
                    state_next      = S_RESULT;
                end
            end
            S_RESULT: begin
                if (!m_tvalid_reg || m_tready) begin
                    m_tvalid_next           = 1'b1;
                    m_result_next.status    = res_status_reg;
                    m_result_next.slot      = (res_status_reg == lpht_pkg::STAT_OK)
                                              ? 4'(res_slot_reg) : 4'd0;
                    m_result_next.occupancy = 5'(live_reg);
                    state_next              = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    // State, counters and the output register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_CLEAR;
            idx_reg      <= '0;
            cnt_reg      <= '0;
            live_reg     <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            idx_reg      <= idx_next;
            cnt_reg      <= cnt_next;
            live_reg     <= live_next;
            m_tvalid_reg <= m_tvalid_next;
        end
        m_result_reg   <= m_result_next;
        kind_reg       <= kind_next;
        key_reg        <= key_next;
        res_status_reg <= res_status_next;
        res_slot_reg   <= res_slot_next;
    end

endmodule
